FILE: hdl/fba_pkg.sv
package fba_pkg;

    localparam int WORD_BITS     = 32;
    localparam int BIT_IDX_W     = 5;
    localparam int MAX_WORDS     = 32;
    localparam int FRAME_W       = 10;
    localparam int COUNT_W       = 11;
    localparam int STATUS_W      = 3;
    localparam int WCOUNT_W      = 6;
    localparam int REQ_W         = 2;
    localparam int NUM_WORDS_DEF = 32;
    localparam logic [WCOUNT_W-1:0] WCOUNT_RESET = 6'd32;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = 11'd1024;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_MARK  = 2'd2,
        REQ_COUNT = 2'd3
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 3'd0,
        STAT_OOM   = 3'd1,
        STAT_USED  = 3'd2,
        STAT_FREE  = 3'd3,
        STAT_RANGE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DONE
    } state_t;

endpackage

FILE: hdl/fba_req_if.sv
interface fba_req_if
    import fba_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [FRAME_W-1:0]  frame_number;

    modport source (output valid, output req_type, output frame_number, input ready);
    modport sink   (input valid, input req_type, input frame_number, output ready);
endinterface

FILE: hdl/fba_rsp_if.sv
interface fba_rsp_if
    import fba_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [FRAME_W-1:0]  frame_number_out;
    logic [COUNT_W-1:0]  free_frames;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output frame_number_out, output free_frames,
                    output status, input ready);
    modport sink   (input valid, input frame_number_out, input free_frames,
                    input status, output ready);
endinterface

FILE: hdl/frame_bitmap_allocator_core.sv
// Free and mark-used read the frame's word and then update it in S_CHECK; an out-of-range
// frame goes straight to S_DONE. Count and allocate scan the live words in S_SCAN, one
// word read per cycle, and an allocate stops at the first word with a clear bit.
// One request is in flight at a time and the next is taken the cycle after its result is
// queued, so an output stall also holds off the next request.
// Reset clears all min(NUM_WORDS, 32) bitmap words in turn; word_count resets to 32.
module frame_bitmap_allocator_core
    import fba_pkg::*;
#(
    parameter int NUM_WORDS = NUM_WORDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    fba_req_if.sink             req,
    fba_rsp_if.source           rsp,
    input  logic                cfg_we,
    input  logic [WCOUNT_W-1:0] cfg_data
);

    localparam int MEM_DEPTH = (NUM_WORDS < MAX_WORDS) ? NUM_WORDS : MAX_WORDS;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [WCOUNT_W-1:0] DEPTH_W = WCOUNT_W'(MEM_DEPTH);

    state_t                 state_reg, state_next;
    logic [WCOUNT_W-1:0]    wcount_reg;
    logic [WCOUNT_W-1:0]    words_reg, words_next;
    req_type_t              req_reg, req_next;
    logic [FRAME_W-1:0]     frame_reg, frame_next;
    logic [WCOUNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [BIT_IDX_W-1:0]   ev_idx_reg, ev_idx_next;
    logic                   pend_reg, pend_next;
    logic [COUNT_W-1:0]     acc_reg, acc_next;
    logic [AW-1:0]          clr_idx_reg, clr_idx_next;
    logic [FRAME_W-1:0]     res_frame_reg, res_frame_next;
    logic [COUNT_W-1:0]     res_count_reg, res_count_next;
    status_t                res_status_reg, res_status_next;
    logic                   out_valid_reg, out_valid_next;
    logic [FRAME_W-1:0]     out_frame_reg, out_frame_next;
    logic [COUNT_W-1:0]     out_count_reg, out_count_next;
    status_t                out_status_reg, out_status_next;

    logic [WORD_BITS-1:0]   mem [MEM_DEPTH];
    logic [WORD_BITS-1:0]   rdata_reg;
    logic                   mem_re, mem_we;
    logic [AW-1:0]          mem_raddr, mem_waddr;
    logic [WORD_BITS-1:0]   mem_wdata;

    logic                   accept;
    logic [WCOUNT_W-1:0]    live_words;
    logic [WCOUNT_W-1:0]    in_widx;
    logic                   in_range;
    logic                   word_full;
    logic [WORD_BITS-1:0]   low_zero;
    logic [BIT_IDX_W-1:0]   low_pos;
    logic                   hit;
    logic                   issue;
    logic                   bit_set;
    logic                   out_free;
    logic [WORD_BITS-1:0]   bit_mask;

    assign accept     = req.valid && req.ready;
    assign live_words = (wcount_reg > DEPTH_W) ? DEPTH_W : wcount_reg;
    assign in_widx    = WCOUNT_W'(req.frame_number[FRAME_W-1:BIT_IDX_W]);
    assign in_range   = in_widx < live_words;
    assign out_free   = !out_valid_reg || rsp.ready;

    // Lowest clear bit as a one-hot word: ~w & (w + 1).
    assign word_full = &rdata_reg;
    assign low_zero  = ~rdata_reg & (rdata_reg + WORD_BITS'(1));
    always_comb
    begin
        low_pos = '0;
        for (int k = 0; k < BIT_IDX_W; k++)
        begin
            for (int j = 0; j < WORD_BITS; j++)
            begin
                if (((j >> k) & 1) == 1)
                begin
                    low_pos[k] = low_pos[k] | low_zero[j];
                end
            end
        end
    end

    assign hit      = (req_reg == REQ_ALLOC) && pend_reg && !word_full;
    assign issue    = (rd_idx_reg < words_reg) && !hit;
    assign bit_set  = rdata_reg[frame_reg[BIT_IDX_W-1:0]];
    assign bit_mask = WORD_BITS'(1) << frame_reg[BIT_IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_idx_reg == AW'(MEM_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_type_t'(req.req_type) == REQ_ALLOC
                        || req_type_t'(req.req_type) == REQ_COUNT)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (in_range)
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_CHECK:
            begin
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (hit || (!pend_reg && !issue))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready       = (state_reg == S_IDLE);
        words_next      = words_reg;
        req_next        = req_reg;
        frame_next      = frame_reg;
        rd_idx_next     = rd_idx_reg;
        ev_idx_next     = ev_idx_reg;
        pend_next       = 1'b0;
        acc_next        = acc_reg;
        clr_idx_next    = clr_idx_reg;
        res_frame_next  = res_frame_reg;
        res_count_next  = res_count_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_frame_next  = out_frame_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + AW'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    words_next      = live_words;
                    req_next        = req_type_t'(req.req_type);
                    frame_next      = req.frame_number;
                    rd_idx_next     = '0;
                    acc_next        = '0;
                    res_frame_next  = req.frame_number;
                    res_count_next  = '0;
                    res_status_next = STAT_RANGE;
                    mem_re          = 1'b1;
                    mem_raddr       = in_widx[AW-1:0];
                end
            end
            S_CHECK:
            begin
                res_status_next = STAT_OK;
                mem_waddr       = frame_reg[BIT_IDX_W +: AW];
                if (req_reg == REQ_FREE)
                begin
                    if (!bit_set)
                    begin
                        res_status_next = STAT_FREE;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = rdata_reg & ~bit_mask;
                    end
                end
                else
                begin
                    if (bit_set)
                    begin
                        res_status_next = STAT_USED;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = rdata_reg | bit_mask;
                    end
                end
            end
            S_SCAN:
            begin
                if (pend_reg && req_reg == REQ_COUNT)
                begin
                    acc_next = acc_reg + COUNT_W'($countones(~rdata_reg));
                end
                if (issue)
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = rd_idx_reg[AW-1:0];
                    pend_next   = 1'b1;
                    ev_idx_next = rd_idx_reg[BIT_IDX_W-1:0];
                    rd_idx_next = rd_idx_reg + WCOUNT_W'(1);
                end
                if (hit)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = ev_idx_reg[AW-1:0];
                    mem_wdata       = rdata_reg | low_zero;
                    res_frame_next  = {ev_idx_reg, low_pos};
                    res_status_next = STAT_OK;
                end
                else if (!pend_reg && !issue)
                begin
                    // The scan ran dry: no free frame, or the count is complete.
                    if (req_reg == REQ_ALLOC)
                    begin
                        res_frame_next  = '0;
                        res_status_next = STAT_OOM;
                    end
                    else
                    begin
                        res_count_next  = acc_reg;
                        res_status_next = STAT_OK;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_frame_next  = res_frame_reg;
                    out_count_next  = res_count_reg;
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.frame_number_out = out_frame_reg;
    assign rsp.free_frames      = out_count_reg;
    assign rsp.status           = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            wcount_reg    <= WCOUNT_RESET;
            pend_reg      <= 1'b0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                wcount_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        words_reg      <= words_next;
        req_reg        <= req_next;
        frame_reg      <= frame_next;
        rd_idx_reg     <= rd_idx_next;
        ev_idx_reg     <= ev_idx_next;
        acc_reg        <= acc_next;
        res_frame_reg  <= res_frame_next;
        res_count_reg  <= res_count_next;
        res_status_reg <= res_status_next;
        out_frame_reg  <= out_frame_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // No request may slip in while the bitmap is still being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !req.ready)
        else $error("request taken during clearing pass");

    // A word under evaluation always lies inside the live words.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && pend_reg) |-> (WCOUNT_W'(ev_idx_reg) < words_reg))
        else $error("scan evaluated a word beyond the live count");

    // The free count can never exceed the frames of 32 words.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (acc_reg <= COUNT_MAX))
        else $error("free count overflow");

    // A finished result moves to the output register when the slot is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result not transferred to output");

    // Out of memory always reports frame zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == STAT_OOM) |-> (out_frame_reg == '0))
        else $error("out of memory with nonzero frame");

endmodule
